### rtl/core/sync_length_crc8_frame_parser_defines.svh
// assertion macros for the frame parser rtl
`ifndef SYNC_LENGTH_CRC8_FRAME_PARSER_DEFINES_SVH
`define SYNC_LENGTH_CRC8_FRAME_PARSER_DEFINES_SVH

// checked on every clock edge outside reset
`define SLCFP_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// checked on every clock edge, reset included
`define SLCFP_ASSERT_ALWAYS(name, prop, msg) \
  name: assert property (@(posedge clk) prop) else $error(msg);

`endif

### rtl/core/slcfp_pkg.sv
package slcfp_pkg;

  // parser phases
  typedef enum logic [2:0] {
    PH_SOF1   = 3'd0,
    PH_SOF2   = 3'd1,
    PH_CMD    = 3'd2,
    PH_SEQ    = 3'd3,
    PH_LEN_LO = 3'd4,
    PH_LEN_HI = 3'd5,
    PH_DATA   = 3'd6,
    PH_CRC    = 3'd7
  } phase_t;

  // configuration register indexes
  typedef enum logic [1:0] {
    REG_SYNC_FIRST  = 2'd0,
    REG_SYNC_SECOND = 2'd1,
    REG_MAX_LEN     = 2'd2
  } reg_idx_t;

  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 16;

  // result kinds
  localparam logic KIND_PAYLOAD = 1'b0;
  localparam logic KIND_END     = 1'b1;

  // crc-8, poly 0x07, init 0x00, no reflection
  localparam logic [7:0] CRC_POLY = 8'h07;
  localparam logic [7:0] CRC_INIT = 8'h00;
  localparam logic [7:0] CRC_TOP  = 8'h80;

  // reset values of the configuration registers
  localparam logic [7:0]  SYNC_FIRST_RST  = 8'hAA;
  localparam logic [7:0]  SYNC_SECOND_RST = 8'h55;
  localparam logic [15:0] MAX_LEN_RST     = 16'd1024;

  // one byte through the crc, unrolled over its eight bits
  function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] c;
    c = crc ^ b;
    for (int k = 0; k < 8; k++) begin
      if ((c & CRC_TOP) != 8'h00) c = {c[6:0], 1'b0} ^ CRC_POLY;
      else c = {c[6:0], 1'b0};
    end
    return c;
  endfunction

endpackage

### rtl/core/slcfp_rx_if.sv
interface slcfp_rx_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

### rtl/core/slcfp_res_if.sv
interface slcfp_res_if;
  logic        valid;
  logic        ready;
  logic        kind;
  logic [7:0]  payload_byte;
  logic [15:0] byte_index;
  logic [7:0]  frame_cmd;
  logic [7:0]  frame_seq;
  logic [15:0] payload_len;
  logic        crc_ok;
  logic        last;

  modport source (
    output valid, output kind, output payload_byte, output byte_index,
    output frame_cmd, output frame_seq, output payload_len, output crc_ok,
    output last, input ready
  );
  modport sink (
    input valid, input kind, input payload_byte, input byte_index,
    input frame_cmd, input frame_seq, input payload_len, input crc_ok,
    input last, output ready
  );
endinterface

### rtl/core/slcfp_cfg_if.sv
interface slcfp_cfg_if;
  import slcfp_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

### rtl/core/sync_length_crc8_frame_parser.sv
// channel  role   payload
// -------  -----  -------------------------------------------------------
// rx       sink   rx_byte
// res      source kind, payload_byte, byte_index, frame_cmd, frame_seq,
//                 payload_len, crc_ok, last
// cfg      sink   index, data (0 sync_first, 1 sync_second, 2 max_payload_len)
//
// one byte per cycle while res does not stall; a byte's result is in the output
// register the cycle after its transaction, set by the crc and phase update
// rx is ready whenever the output register is empty or being taken
// rst is synchronous, active high; config writes are always taken
// a stall on res holds the result and stalls rx from the next byte on
`include "sync_length_crc8_frame_parser_defines.svh"

module sync_length_crc8_frame_parser
  import slcfp_pkg::*;
(
  input logic         clk,
  input logic         rst,
  slcfp_rx_if.sink    rx,
  slcfp_res_if.source res,
  slcfp_cfg_if.sink   cfg
);

  // configuration registers
  logic [7:0]  sync_first;
  logic [7:0]  sync_second;
  logic [15:0] max_payload_len;

  // parser state
  phase_t      phase;
  phase_t      phase_next;
  logic [7:0]  crc;
  logic [7:0]  crc_next;
  logic [7:0]  cmd;
  logic [7:0]  cmd_next;
  logic [7:0]  seq;
  logic [7:0]  seq_next;
  logic [15:0] frame_length;
  logic [15:0] frame_length_next;
  logic [15:0] payload_count;
  logic [15:0] payload_count_next;

  // result register
  logic        res_valid;
  logic        res_kind;
  logic [7:0]  res_payload_byte;
  logic [15:0] res_byte_index;
  logic [7:0]  res_frame_cmd;
  logic [7:0]  res_frame_seq;
  logic [15:0] res_payload_len;
  logic        res_crc_ok;
  logic        res_last;

  logic        emit;
  logic        accept;
  logic [7:0]  b;
  logic [16:0] count_inc;
  logic [15:0] len_full;
  logic [7:0]  crc_seed;

  assign b         = rx.rx_byte;
  assign rx.ready  = !res_valid || res.ready;
  assign accept    = rx.valid && rx.ready;
  assign cfg.ready = 1'b1;
  assign count_inc = {1'b0, payload_count} + 17'd1;
  assign len_full  = {b, frame_length[7:0]};
  assign crc_seed  = (phase == PH_CMD) ? CRC_INIT : crc;

  // next phase
  always_comb begin
    phase_next = phase;
    case (phase)
      PH_SOF1:   if (b == sync_first) phase_next = PH_SOF2;
      PH_SOF2:   phase_next = (b == sync_second) ? PH_CMD : PH_SOF1;
      PH_CMD:    phase_next = PH_SEQ;
      PH_SEQ:    phase_next = PH_LEN_LO;
      PH_LEN_LO: phase_next = PH_LEN_HI;
      PH_LEN_HI: begin
        if (len_full > max_payload_len) phase_next = PH_SOF1;
        else if (len_full == 16'd0) phase_next = PH_CRC;
        else phase_next = PH_DATA;
      end
      PH_DATA:   if (count_inc >= {1'b0, frame_length}) phase_next = PH_CRC;
      PH_CRC:    phase_next = PH_SOF1;
      default:   phase_next = PH_SOF1;
    endcase
  end

  // header, crc and counter updates, result selection
  always_comb begin
    crc_next           = crc;
    cmd_next           = cmd;
    seq_next           = seq;
    frame_length_next  = frame_length;
    payload_count_next = payload_count;
    emit               = 1'b0;
    case (phase)
      PH_CMD: begin
        cmd_next = b;
        crc_next = crc8_byte(crc_seed, b);
      end
      PH_SEQ: begin
        seq_next = b;
        crc_next = crc8_byte(crc_seed, b);
      end
      PH_LEN_LO: begin
        frame_length_next = {8'h00, b};
        crc_next          = crc8_byte(crc_seed, b);
      end
      PH_LEN_HI: begin
        frame_length_next = len_full;
        crc_next          = crc8_byte(crc_seed, b);
        if (len_full <= max_payload_len && len_full != 16'd0) payload_count_next = 16'd0;
      end
      PH_DATA: begin
        crc_next           = crc8_byte(crc_seed, b);
        payload_count_next = count_inc[15:0];
        emit               = 1'b1;
      end
      PH_CRC:  emit = 1'b1;
      default: emit = 1'b0;
    endcase
  end

  // state, configuration and result registers
  always_ff @(posedge clk) begin
    if (rst) begin
      sync_first      <= SYNC_FIRST_RST;
      sync_second     <= SYNC_SECOND_RST;
      max_payload_len <= MAX_LEN_RST;
      phase           <= PH_SOF1;
      crc             <= CRC_INIT;
      cmd             <= 8'h00;
      seq             <= 8'h00;
      frame_length    <= 16'd0;
      payload_count   <= 16'd0;
      res_valid       <= 1'b0;
    end else begin
      if (cfg.valid && cfg.ready) begin
        case (cfg.index)
          REG_SYNC_FIRST:  sync_first      <= cfg.data[7:0];
          REG_SYNC_SECOND: sync_second     <= cfg.data[7:0];
          REG_MAX_LEN:     max_payload_len <= cfg.data;
          default:         ;
        endcase
      end
      if (accept) begin
        phase         <= phase_next;
        crc           <= crc_next;
        cmd           <= cmd_next;
        seq           <= seq_next;
        frame_length  <= frame_length_next;
        payload_count <= payload_count_next;
        res_valid     <= emit;
      end else if (res.ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  // result payload, loaded with each emitting transaction
  always_ff @(posedge clk) begin
    if (accept && emit) begin
      res_frame_cmd   <= cmd;
      res_frame_seq   <= seq;
      res_payload_len <= frame_length;
      if (phase == PH_DATA) begin
        res_kind         <= KIND_PAYLOAD;
        res_payload_byte <= b;
        res_byte_index   <= payload_count;
        res_crc_ok       <= 1'b0;
        res_last         <= 1'b0;
      end else begin
        res_kind         <= KIND_END;
        res_payload_byte <= 8'h00;
        res_byte_index   <= 16'd0;
        res_crc_ok       <= (crc == b);
        res_last         <= 1'b1;
      end
    end
  end

  assign res.valid        = res_valid;
  assign res.kind         = res_kind;
  assign res.payload_byte = res_payload_byte;
  assign res.byte_index   = res_byte_index;
  assign res.frame_cmd    = res_frame_cmd;
  assign res.frame_seq    = res_frame_seq;
  assign res.payload_len  = res_payload_len;
  assign res.crc_ok       = res_crc_ok;
  assign res.last         = res_last;

  // checks
  `SLCFP_ASSERT_ALWAYS(a_reset_clears_result, rst |=> !res.valid, "result valid after reset")
  `SLCFP_ASSERT(a_quiet_phases, (accept && phase != PH_DATA && phase != PH_CRC) |=> !res.valid, "result from a header byte")
  `SLCFP_ASSERT(a_crc_closes_frame, (accept && phase == PH_CRC) |=> (res.valid && res.last && phase == PH_SOF1), "crc byte did not close the frame")
  `SLCFP_ASSERT(a_count_in_range, (phase == PH_DATA) |-> (payload_count < frame_length), "payload count past frame length")

endmodule
